// ----- src/spl_pkg.sv -----
// shared types, codes and control structs for the sorted priority list
package spl_pkg;

  localparam int SPL_CAPACITY = 16;
  localparam int REM_W        = 5;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PURGE  = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        guest_handle;
    logic signed [15:0] priority_req;
    logic signed [15:0] purge_threshold;
  } spl_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        entry_handle;
    logic signed [15:0] entry_priority_out;
    logic [REM_W-1:0]   remaining;
    logic               last;
  } spl_out_t;

  typedef struct packed {
    logic [15:0]        handle;
    logic signed [15:0] prio;
  } spl_entry_t;

  typedef struct packed {
    logic       take_item;
    logic       ptr_from_count;
    logic       rd_below;
    logic       rd_at;
    logic       ins_shift;
    logic       ins_place;
    logic       prg_step;
    logic       prg_done;
    logic       lst_load;
    logic       rsp_load;
    logic [1:0] rsp_status;
  } spl_cmd_t;

  typedef struct packed {
    logic ptr_zero;
    logic ptr_end;
    logic full;
    logic empty;
    logic above;
    logic list_last;
  } spl_stat_t;

endpackage

// ----- src/spl_dp.sv -----
// datapath: slot memory, scan pointers, entry count and output register
module spl_dp #(
  parameter int CAPACITY = spl_pkg::SPL_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spl_pkg::spl_in_t  in_data,
  input  spl_pkg::spl_cmd_t cmd,
  output spl_pkg::spl_stat_t stat,
  output spl_pkg::spl_out_t out_data
);
  import spl_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  spl_entry_t          mem [CAPACITY];
  spl_in_t             item_r;
  spl_entry_t          rd_q_r;
  spl_out_t            out_r;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     ptr_r;
  logic [CntW-1:0]     wptr_r;

  logic [CntW-1:0]     ptr_dec;
  logic [CntW-1:0]     ptr_inc;
  logic [IdxW-1:0]     rd_addr;
  logic [IdxW-1:0]     wr_addr;
  logic                wr_en;
  spl_entry_t          wr_data;
  logic                keep;

  assign ptr_dec = ptr_r - CntW'(1);
  assign ptr_inc = ptr_r + CntW'(1);
  assign keep    = $signed(rd_q_r.prio) < $signed(item_r.purge_threshold);
  assign rd_addr = cmd.rd_below ? ptr_dec[IdxW-1:0] : ptr_r[IdxW-1:0];

  always_comb begin
    wr_en   = cmd.ins_shift | cmd.ins_place | (cmd.prg_step & keep);
    wr_addr = cmd.prg_step ? wptr_r[IdxW-1:0] : ptr_r[IdxW-1:0];
    wr_data = rd_q_r;
    if (cmd.ins_place) begin
      wr_data.handle = item_r.guest_handle;
      wr_data.prio   = item_r.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_below | cmd.rd_at) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r <= in_data;
    end
    if (cmd.lst_load) begin
      out_r.status             <= ST_OK;
      out_r.entry_handle       <= rd_q_r.handle;
      out_r.entry_priority_out <= rd_q_r.prio;
      out_r.remaining          <= REM_W'(count_r);
      out_r.last               <= stat.list_last;
    end else if (cmd.rsp_load) begin
      out_r.status             <= cmd.rsp_status;
      out_r.entry_handle       <= '0;
      out_r.entry_priority_out <= '0;
      out_r.remaining          <= REM_W'(count_r);
      out_r.last               <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      wptr_r  <= '0;
    end else begin
      if (cmd.ins_place) begin
        count_r <= count_r + CntW'(1);
      end else if (cmd.prg_done) begin
        count_r <= wptr_r;
      end

      if (cmd.take_item) begin
        ptr_r <= cmd.ptr_from_count ? count_r : '0;
      end else if (cmd.ins_shift) begin
        ptr_r <= ptr_dec;
      end else if (cmd.prg_step | cmd.lst_load) begin
        ptr_r <= ptr_inc;
      end

      if (cmd.take_item) begin
        wptr_r <= '0;
      end else if (cmd.prg_step & keep) begin
        wptr_r <= wptr_r + CntW'(1);
      end
    end
  end

  always_comb begin
    stat.ptr_zero  = (ptr_r == '0);
    stat.ptr_end   = (ptr_r == count_r);
    stat.full      = (count_r == CntW'(CAPACITY));
    stat.empty     = (count_r == '0);
    stat.above     = $signed(rd_q_r.prio) > $signed(item_r.priority_req);
    stat.list_last = (ptr_inc == count_r);
  end

  assign out_data = out_r;

endmodule

// ----- src/spl_ctrl.sv -----
// controller: sequences insert, purge and list over the slot memory
module spl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic               out_stall,
  input  spl_pkg::spl_stat_t stat,
  output spl_pkg::spl_cmd_t  cmd,
  output logic               in_stall,
  output logic               out_valid
);
  import spl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_PRG_RD, S_PRG_CMP, S_LST_RD, S_LST_OUT, S_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] rsp_status_r, rsp_status_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.rsp_status = rsp_status_r;
    state_nxt      = state_r;
    rsp_status_nxt = rsp_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item  = 1'b1;
          rsp_status_nxt = ST_OK;
          unique case (in_op)
            OP_INSERT: begin
              cmd.ptr_from_count = 1'b1;
              if (stat.full) begin
                rsp_status_nxt = ST_FULL;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            OP_PURGE: state_nxt = S_PRG_RD;
            OP_LIST: begin
              if (stat.empty) begin
                rsp_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_LST_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        if (stat.ptr_zero) begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_below = 1'b1;
          state_nxt    = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // move the larger entry up one slot, or drop the newcomer in behind it
        if (stat.above) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_PRG_RD: begin
        if (stat.ptr_end) begin
          cmd.prg_done = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.rd_at = 1'b1;
          state_nxt = S_PRG_CMP;
        end
      end
      S_PRG_CMP: begin
        cmd.prg_step = 1'b1;
        state_nxt    = S_PRG_RD;
      end
      S_LST_RD: begin
        cmd.rd_at = 1'b1;
        state_nxt = S_LST_OUT;
      end
      S_LST_OUT: begin
        if (out_free) begin
          cmd.lst_load = 1'b1;
          state_nxt    = stat.list_last ? S_IDLE : S_LST_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.rsp_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.lst_load || cmd.rsp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      rsp_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      rsp_status_r <= rsp_status_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/sorted_priority_list_unit.sv -----
// sorted priority list: holds up to CAPACITY (handle, priority) entries in
// ascending priority order, equal priorities kept in arrival order.
// input channel in_valid/in_stall/in_data carries one operation per transfer:
// insert, purge at or above a threshold, or list. operation code 3 is taken
// and dropped with no result.
// output channel out_valid/out_stall/out_data: insert and purge give one
// result, list gives one result per held entry (last marked), or a single
// empty-status result when nothing is held.
// sequencing: one item at a time; in_stall is high from the transfer until the
// final result sits in the output register. the slot memory has one read
// port with registered data, so each visited slot takes a read state and then
// a compare state (insert, purge) or an output state (list); a refused insert
// or an empty list goes straight to the response state.
// a held result waiting on out_stall does not block the next input transfer
// once the last result of the item is loaded; a stalled result holds still.
// reset empties the list (entry count zero) and clears out_valid; the slot
// memory itself is not cleared.
module sorted_priority_list_unit #(
  parameter int CAPACITY = spl_pkg::SPL_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spl_pkg::spl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spl_pkg::spl_out_t out_data
);
  import spl_pkg::*;

  spl_cmd_t  cmd;
  spl_stat_t stat;

  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  spl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ----- src/spl_checker.sv -----
// port-level checks for the sorted priority list, bound to the top level
module spl_checker #(
  parameter int CAPACITY = spl_pkg::SPL_CAPACITY
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input spl_pkg::spl_out_t out_data
);
  import spl_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // refused inserts only happen with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.remaining == REM_W'(CAPACITY))
    else $error("full status with list not at capacity");

  // empty listing carries no entry
  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.last && out_data.remaining == '0 && out_data.entry_handle == '0
      && out_data.entry_priority_out == '0)
    else $error("empty status with entry data");

  // only listing gives more than one result, and only for held entries
  a_multi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK && out_data.remaining != '0)
    else $error("non-final result outside a listing");

endmodule

bind sorted_priority_list_unit spl_checker #(
  .CAPACITY (CAPACITY)
) u_spl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
